// File: rtl/s1fd_pkg.sv
// Shared types and constants for the Steim-1 frame decoder.
// Used by s1fd_word_decode and steim1_frame_decoder; no dependencies.
package s1fd_pkg;

    localparam int WORDS_PER_FRAME = 16;
    localparam int WIF_W           = $clog2(WORDS_PER_FRAME);
    localparam int LANES           = 4;

    // Nibble codes from the frame's code word
    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_BYTE = 2'd1;
    localparam logic [1:0] CODE_HALF = 2'd2;
    localparam logic [1:0] CODE_WORD = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_LITTLE_ENDIAN = 1'b0;
    localparam logic REG_FRAMES        = 1'b1;

    localparam logic [7:0]  FPB_RESET     = 8'd63;
    localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
    localparam logic [WIF_W-1:0] WIF_LAST = WIF_W'(WORDS_PER_FRAME - 1);

    // Decoder state carried from word to word
    typedef struct packed {
        logic [WIF_W-1:0] word_in_frame;
        logic [7:0]       frame_number;
        logic [31:0]      frame_codes;
        logic [31:0]      initial_sample;
        logic [31:0]      previous_sample;
        logic [16:0]      decoded_count;
        logic [15:0]      sample_target;
    } dec_state_t;

    // Results caused by one word: emitted samples, then an optional status
    typedef struct packed {
        logic [LANES-1:0][31:0] samples;
        logic [2:0]             n_emit;
        logic                   has_status;
        logic [16:0]            status_diff;
    } result_set_t;

    // Reverse the four bytes of a word
    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// File: rtl/s1fd_word_decode.sv
// Combinational decode of one data word against the current decoder state.
// Depends on s1fd_pkg for the state and result types.
module s1fd_word_decode import s1fd_pkg::*; (
    input  dec_state_t  st,
    input  logic [31:0] raw_word,
    input  logic [15:0] expected_samples,
    input  logic        little_endian,
    input  logic [7:0]  frames_per_block,
    output dec_state_t  st_next,
    output result_set_t res
);

    logic [31:0]             w32;
    logic                    blk_start;
    logic                    header;
    logic                    active;
    logic                    first;
    logic [1:0]              code;
    logic [15:0]             tgt;
    logic [16:0]             dc;
    logic [2:0]              n_diff;
    logic [LANES-1:0][17:0]  nd;
    logic [LANES-1:0][17:0]  psum;
    logic [LANES-1:0][31:0]  addend;
    logic [31:0]             base;
    logic [LANES-1:0][31:0]  samples;
    logic [16:0]             room;
    logic [2:0]              n_emit;
    logic [17:0]             dc_sum;
    logic [16:0]             dc_new;
    logic [1:0]              last_lane;
    logic [8:0]              fpb_eff;
    logic                    last_word;
    logic [15:0]             h0;
    logic [15:0]             h1;

    // Frame position and block start
    always_comb begin
        w32       = little_endian ? swap32(raw_word) : raw_word;
        blk_start = (st.word_in_frame == '0) && (st.frame_number == 8'd0);
        tgt       = blk_start ? expected_samples : st.sample_target;
        dc        = blk_start ? 17'd0 : st.decoded_count;
        header    = (st.frame_number == 8'd0) &&
                    ((st.word_in_frame == WIF_W'(1)) || (st.word_in_frame == WIF_W'(2)));
        first     = (st.frame_number == 8'd0) && (st.word_in_frame == WIF_W'(3));
        active    = (st.word_in_frame != '0) && !header;
        code      = active ? st.frame_codes[{~st.word_in_frame, 1'b0} +: 2] : CODE_NONE;
    end

    // Split the word into narrow differences
    always_comb begin
        h0 = little_endian ? {raw_word[23:16], raw_word[31:24]} : raw_word[31:16];
        h1 = little_endian ? {raw_word[7:0], raw_word[15:8]} : raw_word[15:0];
        nd = '0;
        n_diff = 3'd0;
        case (code)
            CODE_BYTE: begin
                for (int k = 0; k < LANES; k++) begin
                    nd[k] = {{10{raw_word[31-8*k]}}, raw_word[31-8*k -: 8]};
                end
                n_diff = 3'd4;
            end
            CODE_HALF: begin
                nd[0]  = {{2{h0[15]}}, h0};
                nd[1]  = {{2{h1[15]}}, h1};
                n_diff = 3'd2;
            end
            CODE_WORD: begin
                n_diff = 3'd1;
            end
            default: begin
                n_diff = 3'd0;
            end
        endcase
        // A restart replaces the first difference by the initial value
        if (first) begin
            nd[0] = '0;
        end
    end

    // Prefix sums on narrow values, then one wide add per lane
    always_comb begin
        base    = first ? st.initial_sample : st.previous_sample;
        psum[0] = nd[0];
        for (int k = 1; k < LANES; k++) begin
            psum[k] = psum[k-1] + nd[k];
        end
        for (int k = 0; k < LANES; k++) begin
            addend[k] = {{14{psum[k][17]}}, psum[k]};
        end
        if (code == CODE_WORD) begin
            addend[0] = first ? 32'd0 : w32;
        end
        for (int k = 0; k < LANES; k++) begin
            samples[k] = base + addend[k];
        end
    end

    // Emission count, sample count and block end
    always_comb begin
        room   = ({1'b0, tgt} > dc) ? ({1'b0, tgt} - dc) : 17'd0;
        n_emit = (room < {14'd0, n_diff}) ? room[2:0] : n_diff;
        dc_sum = {1'b0, dc} + {15'd0, n_diff};
        dc_new = dc_sum[17] ? COUNT_MAX : dc_sum[16:0];
        last_lane = 2'(n_diff - 3'd1);
        fpb_eff   = (frames_per_block == 8'd0) ? 9'd256 : {1'b0, frames_per_block};
        last_word = (st.word_in_frame == WIF_LAST) &&
                    (({1'b0, st.frame_number} + 9'd1) >= fpb_eff);
    end

    // Next state
    always_comb begin
        st_next               = st;
        st_next.sample_target = tgt;
        st_next.decoded_count = dc_new;
        if (st.word_in_frame == '0) begin
            st_next.frame_codes = w32;
        end
        if (header && (st.word_in_frame == WIF_W'(1))) begin
            st_next.initial_sample = w32;
        end
        if (n_diff != 3'd0) begin
            st_next.previous_sample = samples[last_lane];
        end
        if (last_word) begin
            st_next.word_in_frame = '0;
            st_next.frame_number  = 8'd0;
        end else if (st.word_in_frame == WIF_LAST) begin
            st_next.word_in_frame = '0;
            st_next.frame_number  = st.frame_number + 8'd1;
        end else begin
            st_next.word_in_frame = st.word_in_frame + WIF_W'(1);
        end
    end

    // Results of this word
    always_comb begin
        res.samples     = samples;
        res.n_emit      = n_emit;
        res.has_status  = last_word;
        res.status_diff = {1'b0, tgt} - dc_new;
    end

endmodule

// File: rtl/steim1_frame_decoder.sv
// Top level of the Steim-1 frame decoder: stream ports, APB registers, result buffer.
// Depends on s1fd_pkg and s1fd_word_decode.

// Decodes a record's Steim-1 data area given as 32-bit words, 16 words to a frame,
// frames_per_block frames to a block. Each word is held in an input register, decoded
// combinationally against the running state, and its results (up to four samples, plus
// a status item on the block's last word) are parked in a result buffer that presents
// one item per cycle on the m_ side while m_tready is high. A word therefore holds the
// buffer until all of its items are taken: four for a word of byte differences, five
// for such a word at block end; a word without results leaves the buffer free. The next
// word is decoded in the cycle the buffer hands over its last item, so the output
// channel, not the decoder, sets the word rate. Words pass the input register and
// the result buffer. Registers: 0x0 little_endian_data (bit 0), 0x4 frames_per_block
// (bits 7:0, 0 means 256, reset 63); write them only while no word is in flight.
module steim1_frame_decoder import s1fd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] data_word, [47:32] expected_samples
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] sample_value, [48:32] count_difference, pad
    output logic        m_tuser,   // [0] is_sample
    output logic        m_tlast    // last_of_run
);

    logic        little_endian_reg;
    logic [7:0]  frames_reg;

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic [15:0] in_exp_reg;

    dec_state_t  state_reg;
    dec_state_t  state_next;
    result_set_t res_next;
    result_set_t res_reg;
    logic [2:0]  idx_reg;
    logic [2:0]  total_reg;

    logic        cfg_write;
    logic        buf_free;
    logic        decode_fire;
    logic        out_fire;
    logic        cur_is_sample;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            little_endian_reg <= 1'b0;
            frames_reg        <= FPB_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_LITTLE_ENDIAN: little_endian_reg <= pwdata[0];
                REG_FRAMES:        frames_reg        <= pwdata[7:0];
                default:           frames_reg        <= frames_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LITTLE_ENDIAN: prdata = {31'd0, little_endian_reg};
            REG_FRAMES:        prdata = {24'd0, frames_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Handshake control: decode when the buffer empties or hands over its last item
    assign out_fire    = m_tvalid && m_tready;
    assign buf_free    = (idx_reg == total_reg) ||
                         (out_fire && ((idx_reg + 3'd1) == total_reg));
    assign decode_fire = in_valid_reg && buf_free;
    assign s_tready    = !in_valid_reg || decode_fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (decode_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= s_tdata[31:0];
            in_exp_reg  <= s_tdata[47:32];
        end
    end

    s1fd_word_decode u_decode (
        .st               (state_reg),
        .raw_word         (in_word_reg),
        .expected_samples (in_exp_reg),
        .little_endian    (little_endian_reg),
        .frames_per_block (frames_reg),
        .st_next          (state_next),
        .res              (res_next)
    );

    // Decoder state and result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            idx_reg   <= 3'd0;
            total_reg <= 3'd0;
        end else if (decode_fire) begin
            state_reg <= state_next;
            idx_reg   <= 3'd0;
            total_reg <= res_next.n_emit + {2'd0, res_next.has_status};
        end else if (out_fire) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Result buffer payload
    always_ff @(posedge aclk) begin
        if (decode_fire) begin
            res_reg <= res_next;
        end
    end

    // Present the current item of the buffer
    assign cur_is_sample = idx_reg < res_reg.n_emit;
    assign m_tvalid      = idx_reg != total_reg;
    assign m_tuser       = cur_is_sample;
    assign m_tlast       = (idx_reg + 3'd1) == total_reg;
    assign m_tdata       = {7'd0,
                            cur_is_sample ? 17'd0 : res_reg.status_diff,
                            cur_is_sample ? res_reg.samples[idx_reg[1:0]] : 32'd0};

`ifndef ASSERT_OFF
    // The buffer never holds more than four samples and one status item
    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= 3'd5)
        else $error("result buffer count out of range");

    // A status item always closes the run of its word
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("status item is not the last of its word");

    // A word waiting on a busy buffer is kept
    a_word_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !decode_fire) |=> (in_valid_reg && $stable(in_word_reg)))
        else $error("pending word lost");

    // The sample target is taken from the block's first word
    a_target_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (decode_fire && (state_reg.word_in_frame == '0) && (state_reg.frame_number == 8'd0))
        |=> (state_reg.sample_target == $past(in_exp_reg)))
        else $error("sample target not latched at block start");
`endif

endmodule
